FILE: rtl/m4inv_pkg.sv
// Shared types and microcode for the 4x4 adjugate inverse block.
// Holds the ALU opcode enum, sequencer states and the two microprograms.
// No dependencies.
`default_nettype none
package m4inv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_WIDTH      = 32;
  localparam int IN_WIDTH       = 32;
  localparam int DET_LEN        = 100;
  localparam int COF_LEN        = 29;
  localparam int PC_W           = 7;

  // Register file map: 0..15 matrix, 16..31 scratch
  localparam logic [4:0] R_SCR = 5'd26;
  localparam logic [4:0] R_ACC = 5'd27;
  localparam logic [4:0] R_Y   = 5'd28;
  localparam logic [4:0] R_RC  = 5'd31;

  typedef enum logic [2:0] {
    OP_LD,    // acc = opnd
    OP_ST,    // rf[sel] = acc
    OP_MUL,   // acc = acc * opnd
    OP_ADD,   // acc = opnd + acc
    OP_SUB,   // acc = acc - opnd
    OP_SUBR,  // acc = opnd - acc
    OP_NEGC   // acc = -acc when the cofactor sign is negative
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] sel;
  } instr_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DET,
    S_CHK,
    S_DIV,
    S_COF,
    S_EMIT
  } state_t;

  // Determinant: six 2x2 minors of rows 2..3, four partial terms, first-row expansion
  localparam instr_t DET_PROG [DET_LEN] = '{
    '{OP_LD,5'd10}, '{OP_MUL,5'd15}, '{OP_ST,5'd26}, '{OP_LD,5'd11}, '{OP_MUL,5'd14},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd16},
    '{OP_LD,5'd9}, '{OP_MUL,5'd15}, '{OP_ST,5'd26}, '{OP_LD,5'd11}, '{OP_MUL,5'd13},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd17},
    '{OP_LD,5'd9}, '{OP_MUL,5'd14}, '{OP_ST,5'd26}, '{OP_LD,5'd10}, '{OP_MUL,5'd13},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd18},
    '{OP_LD,5'd8}, '{OP_MUL,5'd15}, '{OP_ST,5'd26}, '{OP_LD,5'd11}, '{OP_MUL,5'd12},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd19},
    '{OP_LD,5'd8}, '{OP_MUL,5'd14}, '{OP_ST,5'd26}, '{OP_LD,5'd10}, '{OP_MUL,5'd12},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd20},
    '{OP_LD,5'd8}, '{OP_MUL,5'd13}, '{OP_ST,5'd26}, '{OP_LD,5'd9}, '{OP_MUL,5'd12},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd21},
    '{OP_LD,5'd16}, '{OP_MUL,5'd5}, '{OP_ST,5'd26}, '{OP_LD,5'd17}, '{OP_MUL,5'd6},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd26}, '{OP_LD,5'd18}, '{OP_MUL,5'd7}, '{OP_ADD,5'd26},
    '{OP_ST,5'd22},
    '{OP_LD,5'd16}, '{OP_MUL,5'd4}, '{OP_ST,5'd26}, '{OP_LD,5'd19}, '{OP_MUL,5'd6},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd26}, '{OP_LD,5'd20}, '{OP_MUL,5'd7}, '{OP_ADD,5'd26},
    '{OP_ST,5'd23},
    '{OP_LD,5'd17}, '{OP_MUL,5'd4}, '{OP_ST,5'd26}, '{OP_LD,5'd19}, '{OP_MUL,5'd5},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd26}, '{OP_LD,5'd21}, '{OP_MUL,5'd7}, '{OP_ADD,5'd26},
    '{OP_ST,5'd24},
    '{OP_LD,5'd18}, '{OP_MUL,5'd4}, '{OP_ST,5'd26}, '{OP_LD,5'd20}, '{OP_MUL,5'd5},
    '{OP_SUBR,5'd26}, '{OP_ST,5'd26}, '{OP_LD,5'd21}, '{OP_MUL,5'd6}, '{OP_ADD,5'd26},
    '{OP_ST,5'd25},
    '{OP_LD,5'd0}, '{OP_MUL,5'd22}, '{OP_ST,5'd27},
    '{OP_LD,5'd1}, '{OP_MUL,5'd23}, '{OP_SUBR,5'd27}, '{OP_ST,5'd27},
    '{OP_LD,5'd2}, '{OP_MUL,5'd24}, '{OP_ADD,5'd27}, '{OP_ST,5'd27},
    '{OP_LD,5'd3}, '{OP_MUL,5'd25}, '{OP_SUBR,5'd27}
  };

  // Cofactor: sel below 16 names element 0..8 of the 3x3 submatrix
  localparam instr_t COF_PROG [COF_LEN] = '{
    '{OP_LD,5'd4}, '{OP_MUL,5'd8}, '{OP_ST,R_SCR}, '{OP_LD,5'd5}, '{OP_MUL,5'd7},
    '{OP_SUBR,R_SCR}, '{OP_MUL,5'd0}, '{OP_ST,R_ACC},
    '{OP_LD,5'd3}, '{OP_MUL,5'd8}, '{OP_ST,R_SCR}, '{OP_LD,5'd5}, '{OP_MUL,5'd6},
    '{OP_SUBR,R_SCR}, '{OP_MUL,5'd1}, '{OP_ST,R_Y},
    '{OP_LD,5'd3}, '{OP_MUL,5'd7}, '{OP_ST,R_SCR}, '{OP_LD,5'd4}, '{OP_MUL,5'd6},
    '{OP_SUBR,R_SCR}, '{OP_MUL,5'd2}, '{OP_ST,R_SCR},
    '{OP_LD,R_ACC}, '{OP_SUB,R_Y}, '{OP_ADD,R_SCR}, '{OP_NEGC,5'd0}, '{OP_MUL,R_RC}
  };

  // Submatrix element number to its row and column among the three kept
  function automatic logic [1:0] sub_row(input logic [3:0] j);
    case (j)
      4'd0, 4'd1, 4'd2: sub_row = 2'd0;
      4'd3, 4'd4, 4'd5: sub_row = 2'd1;
      default:          sub_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] sub_col(input logic [3:0] j);
    case (j)
      4'd0, 4'd3, 4'd6: sub_col = 2'd0;
      4'd1, 4'd4, 4'd7: sub_col = 2'd1;
      default:          sub_col = 2'd2;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mat4_inverse_cofactor.sv
// 4x4 matrix inverse by adjugate and determinant reciprocal, fixed point.
// Uses m4inv_pkg for the microprograms, opcodes and state type.
//
// Input: s_tvalid/s_tready/s_tdata, one matrix element (signed fixed point) per
// word, row-major. s_tready is high only while the block collects a matrix.
// Output: m_tvalid/m_tready/m_tdata/m_tlast/m_tuser, sixteen inverse elements
// in row-major order; m_tlast marks the sixteenth, m_tuser flags a zero
// determinant (values are then zero).
// All arithmetic runs on one multiply/add unit with an accumulator, stepped by
// a microcode sequencer, plus a one-bit-per-cycle restoring divider for the
// reciprocal. After the sixteenth word the sequencer runs the determinant
// program, a zero check and the reciprocal divide, then per element the
// cofactor program and one output load. A singular matrix skips division
// and cofactors and emits its sixteen words straight after the check.
// When the receiver stalls, the output register holds and the sequencer waits.
// Reset empties the output register and restarts collection at element zero.
`default_nettype none
module mat4_inverse_cofactor #(
  parameter int DATA_WIDTH = m4inv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] element_value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] inverse_value, [35:32] element_index
  output logic             m_tlast,
  output logic             m_tuser    // singular
);

  localparam int W    = DATA_WIDTH;
  localparam int NW   = ((2*FRAC_BITS+1 > W) ? 2*FRAC_BITS+1 : W) + 1;
  localparam int CW   = $clog2(NW+1);
  localparam int XW   = W + 32;
  localparam logic [W-1:0] FX_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] FX_MIN = {1'b1, {(W-1){1'b0}}};

  m4inv_pkg::state_t state, state_next;

  logic [W-1:0] rf [32];
  logic [3:0]   load_count;
  logic [m4inv_pkg::PC_W-1:0] pc;
  logic [3:0]   k;
  logic [W-1:0] acc, acc_next;
  logic         sing;
  logic [W-1:0] dvsr;
  logic [W-1:0] rem;
  logic [NW-1:0] nq;
  logic [CW-1:0] div_cnt;

  m4inv_pkg::instr_t instr;
  logic [4:0]   addr;
  logic [W-1:0] opnd;
  logic         alu_en, in_fire, emit_fire, div_last, det_last, cof_last;

  // Control decode
  always_comb begin
    s_tready  = (state == m4inv_pkg::S_LOAD);
    in_fire   = s_tvalid && s_tready;
    alu_en    = (state == m4inv_pkg::S_DET) || (state == m4inv_pkg::S_COF);
    emit_fire = (state == m4inv_pkg::S_EMIT) && (!m_tvalid || m_tready);
    div_last  = (div_cnt == CW'(1));
    det_last  = (pc == m4inv_pkg::PC_W'(m4inv_pkg::DET_LEN-1));
    cof_last  = (pc == m4inv_pkg::PC_W'(m4inv_pkg::COF_LEN-1));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      m4inv_pkg::S_LOAD: if (in_fire && load_count == 4'd15) state_next = m4inv_pkg::S_DET;
      m4inv_pkg::S_DET:  if (det_last) state_next = m4inv_pkg::S_CHK;
      m4inv_pkg::S_CHK:  state_next = (acc == '0) ? m4inv_pkg::S_EMIT : m4inv_pkg::S_DIV;
      m4inv_pkg::S_DIV:  if (div_last) state_next = m4inv_pkg::S_COF;
      m4inv_pkg::S_COF:  if (cof_last) state_next = m4inv_pkg::S_EMIT;
      m4inv_pkg::S_EMIT: begin
        if (emit_fire) begin
          if (k == 4'd15) state_next = m4inv_pkg::S_LOAD;
          else if (!sing) state_next = m4inv_pkg::S_COF;
        end
      end
      default: state_next = m4inv_pkg::S_LOAD;
    endcase
  end

  // Operand fetch: cofactor mode maps submatrix element numbers to matrix cells
  always_comb begin
    logic [1:0] sr, sc, row, col;
    instr = (state == m4inv_pkg::S_COF) ? m4inv_pkg::COF_PROG[pc[4:0]]
                                        : m4inv_pkg::DET_PROG[pc];
    sr  = m4inv_pkg::sub_row(instr.sel[3:0]);
    sc  = m4inv_pkg::sub_col(instr.sel[3:0]);
    row = (sr >= k[1:0]) ? sr + 2'd1 : sr;
    col = (sc >= k[3:2]) ? sc + 2'd1 : sc;
    if (state == m4inv_pkg::S_COF && !instr.sel[4]) addr = {1'b0, row, col};
    else addr = instr.sel;
    opnd = rf[addr];
  end

  // Shared arithmetic unit
  always_comb begin
    logic [W-1:0]   ma, mb;
    logic [2*W-1:0] prod;
    logic [2*W:0]   rnd;
    logic [2*W:0]   q;
    logic [W:0]     s;
    logic [W:0]     x, y;
    logic           neg, sub;
    ma   = acc[W-1] ? W'(-acc) : acc;
    mb   = opnd[W-1] ? W'(-opnd) : opnd;
    prod = (2*W)'(ma) * (2*W)'(mb);
    rnd  = {1'b0, prod} + ((2*W+1)'(1) << (FRAC_BITS-1));
    q    = rnd >> FRAC_BITS;
    neg  = acc[W-1] ^ opnd[W-1];
    x    = {opnd[W-1], opnd};
    y    = {acc[W-1], acc};
    sub  = 1'b0;
    case (instr.op)
      m4inv_pkg::OP_SUB:  begin x = {acc[W-1], acc}; y = {opnd[W-1], opnd}; sub = 1'b1; end
      m4inv_pkg::OP_SUBR: sub = 1'b1;
      m4inv_pkg::OP_NEGC: begin x = '0; sub = 1'b1; end
      default: ;
    endcase
    s = sub ? x - y : x + y;
    case (instr.op)
      m4inv_pkg::OP_LD:  acc_next = opnd;
      m4inv_pkg::OP_ST:  acc_next = acc;
      m4inv_pkg::OP_MUL: begin
        if (q > (2*W+1)'(FX_MAX)) acc_next = neg ? FX_MIN : FX_MAX;
        else acc_next = neg ? W'(-q[W-1:0]) : q[W-1:0];
      end
      m4inv_pkg::OP_NEGC: begin
        if (!(k[0] ^ k[2])) acc_next = acc;
        else if (s[W] != s[W-1]) acc_next = s[W] ? FX_MIN : FX_MAX;
        else acc_next = s[W-1:0];
      end
      default: begin
        if (s[W] != s[W-1]) acc_next = s[W] ? FX_MIN : FX_MAX;
        else acc_next = s[W-1:0];
      end
    endcase
  end

  // Input clamp to W bits, output clamp to 32 bits
  logic [XW-1:0] in_ext, acc_ext;
  logic [W-1:0]  in_sat;
  logic [31:0]   out_sat;
  always_comb begin
    in_ext  = {{W{s_tdata[31]}}, s_tdata};
    acc_ext = {{32{acc[W-1]}}, acc};
    if ($signed(in_ext) > $signed({{32{1'b0}}, FX_MAX})) in_sat = FX_MAX;
    else if ($signed(in_ext) < $signed({{32{1'b1}}, FX_MIN})) in_sat = FX_MIN;
    else in_sat = in_ext[W-1:0];
    if ($signed(acc_ext) > $signed(XW'(32'h7fff_ffff))) out_sat = 32'h7fff_ffff;
    else if ($signed(acc_ext) < $signed({{W{1'b1}}, 32'h8000_0000})) out_sat = 32'h8000_0000;
    else out_sat = acc_ext[31:0];
  end

  // Divider step: restoring, one quotient bit per cycle
  logic [W:0]    trial;
  logic          ge;
  logic [NW-1:0] rc_q;
  logic [W-1:0]  rc;
  always_comb begin
    trial = {rem, nq[NW-1]};
    ge    = trial >= {1'b0, dvsr};
    rc_q  = {nq[NW-2:0], ge};
    if (rc_q > NW'(FX_MAX)) rc = sing ? FX_MIN : FX_MAX;
    else rc = sing ? W'(-rc_q[W-1:0]) : rc_q[W-1:0];
  end

  // Register file: matrix and scratch
  always_ff @(posedge clk) begin
    if (in_fire) rf[{1'b0, load_count}] <= in_sat;
    else if (alu_en && instr.op == m4inv_pkg::OP_ST) rf[addr] <= acc;
    else if (state == m4inv_pkg::S_DIV && div_last) rf[m4inv_pkg::R_RC] <= rc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= m4inv_pkg::S_LOAD;
      load_count <= '0;
      pc         <= '0;
      k          <= '0;
      m_tvalid   <= 1'b0;
      sing       <= 1'b0;
      div_cnt    <= '0;
    end else begin
      state <= state_next;
      if (in_fire) load_count <= load_count + 4'd1;
      if (alu_en) begin
        acc <= acc_next;
        pc  <= (det_last || cof_last) && state_next != state ? '0
             : pc + m4inv_pkg::PC_W'(1);
      end
      case (state)
        m4inv_pkg::S_LOAD: pc <= '0;
        m4inv_pkg::S_CHK: begin
          // sing doubles as the reciprocal sign until the divide finishes
          sing    <= (acc == '0) ? 1'b1 : acc[W-1];
          dvsr    <= acc[W-1] ? W'(-acc) : acc;
          nq      <= (NW'(1) << (2*FRAC_BITS))
                   + NW'((acc[W-1] ? W'(-acc) : acc) >> 1);
          rem     <= '0;
          div_cnt <= CW'(NW);
          k       <= '0;
        end
        m4inv_pkg::S_DIV: begin
          rem     <= ge ? W'(trial - {1'b0, dvsr}) : trial[W-1:0];
          nq      <= rc_q;
          div_cnt <= div_cnt - CW'(1);
          if (div_last) sing <= 1'b0;
        end
        default: ;
      endcase
      if (emit_fire) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {4'd0, k, sing ? 32'd0 : out_sat};
        m_tlast  <= (k == 4'd15);
        m_tuser  <= sing;
        k        <= k + 4'd1;
        pc       <= '0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'd0))
    else $error("singular word carries nonzero value");
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (in_fire && load_count == 4'd15) |=> !s_tready)
    else $error("input taken while computing");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == m4inv_pkg::S_DIV) |-> (dvsr != '0))
    else $error("divide by zero determinant");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[35:32] == 4'd15)))
    else $error("tlast and index disagree");
`endif

endmodule
`default_nettype wire
